// File: src/assert_macros.svh
// Assertion macros shared by the sliding-window median RTL.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Whenever the antecedent holds, the consequent must hold as well.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: src/swm_pkg.sv
// Shared types and constants of the sliding-window median unit.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

    // Width and reset value of the window size register.
    localparam int unsigned     CFG_BITS  = 7;
    localparam logic [6:0]      CFG_RESET = 7'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;      // item transaction accepted, latch it
        logic load;       // capture the leaving sample, write the ring
        logic merge;      // one step of the sorted-window rebuild
        logic finish;     // commit counters, swap banks, load the result
        logic cfg_write;  // window size written, window emptied
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic merge_last; // the current merge step writes the final entry
        logic has_result; // the item in work completes a full window
    } dp_status_t;

endpackage

`default_nettype wire

// File: src/swm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; used for the arrival ring and both sorted-window banks.
`timescale 1ns / 1ps
`default_nettype none

module swm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: src/swm_ctrl.sv
// Controller of the sliding-window median unit: sequences one item through
// load, merge and finish, and owns the handshakes. Depends on swm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swm_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output swm_pkg::dp_cmd_t    cmd,
    input  swm_pkg::dp_status_t status
);

    import swm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MERGE,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign m_tvalid = m_valid_reg;
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        cmd          = '0;
        s_tready     = 1'b0;
        cfg_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                cfg_ready     = 1'b1;
                s_tready      = !cfg_valid;
                cmd.cfg_write = cfg_valid;
                if (s_tvalid && !cfg_valid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                state_next = ST_MERGE;
            end
            ST_MERGE: begin
                cmd.merge = 1'b1;
                if (status.merge_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // A result may only land once the output register is free.
                if (!status.has_result || out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                    if (status.has_result) begin
                        m_valid_next = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: src/swm_datapath.sv
// Datapath of the sliding-window median unit: arrival ring, two sorted banks,
// merge engine, counters and result register. Depends on swm_pkg and swm_ram.
`timescale 1ns / 1ps
`default_nettype none

module swm_datapath #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  swm_pkg::dp_cmd_t                 cmd,
    output swm_pkg::dp_status_t              status,
    input  logic [SAMPLE_BITS-1:0]           sample_in,
    input  logic                             restart_in,
    input  logic [swm_pkg::CFG_BITS-1:0]     cfg_data,
    output logic signed [SAMPLE_BITS:0]      median_doubled
);

    import swm_pkg::*;

    localparam int ADDR_W = $clog2(WINDOW_MAX);
    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
    localparam int CMP_W  = (CNT_W > CFG_BITS) ? CNT_W : CFG_BITS;

    // Control state.
    logic [CFG_BITS-1:0] wsize_reg;
    logic [CNT_W-1:0]    fill_reg;
    logic [ADDR_W-1:0]   ptr_reg;
    logic                bank_reg;
    logic                full_reg;
    logic                res_reg;
    logic [CNT_W-1:0]    i_reg, i_next;
    logic [CNT_W-1:0]    j_reg;
    logic                rem_done_reg;
    logic                ins_done_reg;

    // Payload registers.
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [SAMPLE_BITS-1:0] old_reg;
    logic signed [SAMPLE_BITS-1:0] lo_reg;
    logic signed [SAMPLE_BITS-1:0] hi_reg;
    logic signed [SAMPLE_BITS:0]   median_reg;

    logic [CNT_W-1:0]  w_eff;
    logic [CMP_W-1:0]  wsize_ext;
    logic              empty_c;
    logic [CNT_W-1:0]  fill_c;
    logic              full_c;
    logic [CNT_W-1:0]  out_len;
    logic [CNT_W-1:0]  lo_idx;
    logic [CNT_W-1:0]  hi_idx;
    logic [CNT_W-1:0]  ptr_inc;

    logic [SAMPLE_BITS-1:0]        ring_rdata;
    logic [SAMPLE_BITS-1:0]        bank0_rdata;
    logic [SAMPLE_BITS-1:0]        bank1_rdata;
    logic signed [SAMPLE_BITS-1:0] v;
    logic                          have_v;
    logic                          skip_v;
    logic                          put_s;
    logic                          put_v;
    logic                          wr_en;
    logic [SAMPLE_BITS-1:0]        wr_data;
    logic [ADDR_W-1:0]             ring_waddr;

    // Effective window size: zero acts as one, oversize is clipped.
    assign wsize_ext = CMP_W'(wsize_reg);
    always_comb begin
        if (wsize_ext == '0) begin
            w_eff = CNT_W'(1);
        end else if (wsize_ext > CMP_W'(WINDOW_MAX)) begin
            w_eff = CNT_W'(WINDOW_MAX);
        end else begin
            w_eff = CNT_W'(wsize_ext);
        end
    end

    assign empty_c = restart_in || (fill_reg > w_eff);
    assign fill_c  = empty_c ? '0 : fill_reg;
    assign full_c  = (fill_c == w_eff);

    // A full window keeps its length; a filling one grows by one entry.
    assign out_len = full_reg ? fill_reg : fill_reg + 1'b1;
    assign lo_idx  = (w_eff - 1'b1) >> 1;
    assign hi_idx  = w_eff >> 1;
    assign ptr_inc = CNT_W'(ptr_reg) + 1'b1;

    assign ring_waddr = full_reg ? ptr_reg : fill_reg[ADDR_W-1:0];

    // Merge step: drop one copy of the leaving sample, insert the new one.
    assign v      = bank_reg ? bank1_rdata : bank0_rdata;
    assign have_v = (i_reg < fill_reg);
    assign skip_v = have_v && !rem_done_reg && (v == old_reg);
    assign put_s  = !skip_v && !ins_done_reg && (!have_v || (v > sample_reg));
    assign put_v  = !skip_v && !put_s && have_v;
    assign wr_en  = cmd.merge && (put_s || put_v);
    assign wr_data = put_s ? sample_reg : v;

    always_comb begin
        if (cmd.start) begin
            i_next = '0;
        end else if (cmd.merge && (skip_v || put_v)) begin
            i_next = i_reg + 1'b1;
        end else begin
            i_next = i_reg;
        end
    end

    assign status.merge_last = wr_en && (j_reg == out_len - 1'b1);
    assign status.has_result = res_reg;
    assign median_doubled    = median_reg;

    swm_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW_MAX)) u_ring (
        .clk   (aclk),
        .we    (cmd.load),
        .waddr (ring_waddr),
        .wdata (sample_reg),
        .raddr (ptr_reg),
        .rdata (ring_rdata)
    );

    swm_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW_MAX)) u_bank0 (
        .clk   (aclk),
        .we    (wr_en && bank_reg),
        .waddr (j_reg[ADDR_W-1:0]),
        .wdata (wr_data),
        .raddr (i_next[ADDR_W-1:0]),
        .rdata (bank0_rdata)
    );

    swm_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW_MAX)) u_bank1 (
        .clk   (aclk),
        .we    (wr_en && !bank_reg),
        .waddr (j_reg[ADDR_W-1:0]),
        .wdata (wr_data),
        .raddr (i_next[ADDR_W-1:0]),
        .rdata (bank1_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wsize_reg    <= CFG_RESET;
            fill_reg     <= '0;
            ptr_reg      <= '0;
            bank_reg     <= 1'b0;
            full_reg     <= 1'b0;
            res_reg      <= 1'b0;
            i_reg        <= '0;
            j_reg        <= '0;
            rem_done_reg <= 1'b1;
            ins_done_reg <= 1'b1;
        end else begin
            i_reg <= i_next;
            if (cmd.cfg_write) begin
                wsize_reg <= cfg_data;
                fill_reg  <= '0;
                ptr_reg   <= '0;
            end
            if (cmd.start) begin
                fill_reg     <= fill_c;
                full_reg     <= full_c;
                res_reg      <= full_c || (fill_c + 1'b1 == w_eff);
                j_reg        <= '0;
                rem_done_reg <= !full_c;
                ins_done_reg <= 1'b0;
                if (empty_c) begin
                    ptr_reg <= '0;
                end
            end
            if (cmd.merge) begin
                if (wr_en) begin
                    j_reg <= j_reg + 1'b1;
                end
                if (skip_v) begin
                    rem_done_reg <= 1'b1;
                end
                if (put_s) begin
                    ins_done_reg <= 1'b1;
                end
            end
            if (cmd.finish) begin
                bank_reg <= !bank_reg;
                if (full_reg) begin
                    ptr_reg <= (ptr_inc >= w_eff) ? '0 : ADDR_W'(ptr_inc);
                end else begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            sample_reg <= sample_in;
        end
        if (cmd.load) begin
            old_reg <= ring_rdata;
        end
        if (wr_en && (j_reg == lo_idx)) begin
            lo_reg <= wr_data;
        end
        if (wr_en && (j_reg == hi_idx)) begin
            hi_reg <= wr_data;
        end
        if (cmd.finish && res_reg) begin
            median_reg <= (SAMPLE_BITS + 1)'(lo_reg) + (SAMPLE_BITS + 1)'(hi_reg);
        end
    end

endmodule

`default_nettype wire

// File: src/sliding_window_median_unit.sv
// Sliding-window median unit. Each input transaction carries one signed
// sample; the unit keeps the last window_size samples (1 to WINDOW_MAX, a
// size of zero acts as one and larger sizes are clipped) and, once the window
// is full, returns one output transaction per sample holding twice the window
// median: two times the middle value for an odd window, the sum of the two
// middle values for an even one, so the result is exact with no rounding.
// Until the window is full a sample produces no output. Setting tuser on an
// input transaction empties the window before that sample enters, and any
// write of window_size empties it too. Samples are processed one at a time:
// an item is accepted, the leaving sample is read from the arrival ring,
// one merge step runs per entry of the rebuilt sorted window (plus one when
// the leaving sample is dropped), and a finish step commits the item. The
// merge engine streams the sorted window through a single read port of one
// sorted bank into the other bank, one entry per cycle. The next sample is
// taken while a finished result still waits in the output register. Storage
// needs no clearing pass after reset.
// Depends on swm_pkg, swm_ctrl, swm_datapath, swm_ram and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sliding_window_median_unit #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // Input stream.
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // tdata fields from bit 0 up: sample (SAMPLE_BITS, signed), zero padding.
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // tuser fields from bit 0 up: restart.
    input  logic [0:0]                             s_tuser,
    // Result stream.
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // tdata fields from bit 0 up: median_doubled (SAMPLE_BITS + 1, signed),
    // zero padding.
    output logic [((SAMPLE_BITS + 8) / 8) * 8 - 1:0] m_tdata,
    // Configuration write channel for window_size.
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [swm_pkg::CFG_BITS-1:0]           cfg_data
);

    import swm_pkg::*;

    dp_cmd_t                     cmd;
    dp_status_t                  status;
    logic signed [SAMPLE_BITS:0] median_doubled;

    // The controller sequences each transaction and owns all handshakes.
    swm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .status    (status)
    );

    // The datapath holds the window storage, the merge engine and the result.
    swm_datapath #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .sample_in      (s_tdata[SAMPLE_BITS-1:0]),
        .restart_in     (s_tuser[0]),
        .cfg_data       (cfg_data),
        .median_doubled (median_doubled)
    );

    // The result sits in the low bits; the padding up to whole bytes is zero.
    always_comb begin
        m_tdata                = '0;
        m_tdata[SAMPLE_BITS:0] = median_doubled;
    end

    // Items are processed one at a time, so an accepted transaction must drop
    // ready on the following cycle.
    `ASSERT_IMPLIES(a_one_item_in_flight, aclk, aresetn,
        s_tvalid && s_tready, ##1 !s_tready,
        "input accepted while an item is still being processed")

    // A new result only appears after a finish step that completed a window.
    `ASSERT_IMPLIES(a_result_from_finish, aclk, aresetn,
        $rose(m_tvalid), $past(cmd.finish && status.has_result),
        "output valid raised without a finished full-window item")

    // The window size may never change while the merge engine is running.
    `ASSERT_ALWAYS(a_cfg_only_idle, aclk, aresetn,
        !(cmd.cfg_write && (cmd.merge || cmd.load || cmd.finish)),
        "configuration write taken while an item was in progress")

endmodule

`default_nettype wire
